[rtl/core/efg_pkg.sv]
// ----------------------------------------------------------------------------
// Event flag group engine package
// Shared codes, types and default sizes of the event flag group engine.
// ----------------------------------------------------------------------------
package efg_pkg;

	// Default sizes, used as parameter defaults on the top level.
	localparam int GROUPS_DEF    = 4;
	localparam int WAITERS_DEF   = 8;
	localparam int FLAG_BITS_DEF = 32;

	// Fixed field widths of the request and result channels.
	localparam int MODE_W   = 2;
	localparam int GROUP_W  = 2;
	localparam int MASK_W   = 32;
	localparam int TASK_W   = 8;
	localparam int FLAG_W   = 32;
	localparam int STATUS_W = 2;
	localparam int GIU_W    = 3;

	localparam logic [GIU_W-1:0] GIU_RESET = 3'd4;

	// Request operation codes; the unused code falls to a default arm.
	typedef enum logic [MODE_W-1:0] {
		MODE_SET  = 2'd0,
		MODE_CLR  = 2'd1,
		MODE_WAIT = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOGRP   = 2'd3
	} status_t;

	// Result kinds.
	localparam logic KIND_RESULT  = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_WRD  = 5'b00100,
		S_WEV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

endpackage

[rtl/core/efg_waiter_ram.sv]
// ----------------------------------------------------------------------------
// Event flag group waiter memory
// One write port and one registered read port holding the waiter entries.
// ----------------------------------------------------------------------------
module efg_waiter_ram #(
	parameter int DEPTH = efg_pkg::GROUPS_DEF * efg_pkg::WAITERS_DEF,
	parameter int DW    = 1 + efg_pkg::TASK_W + efg_pkg::FLAG_BITS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/event_flag_group_engine.sv]
// ----------------------------------------------------------------------------
// Event flag group engine
// Event flag groups with ordered tables of blocked waiters, as an RTOS
// offload: set, clear and wait requests, release reports for waiters.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -----------------------------------
//  request   in         in_valid / in_stall   mode, group, mask, all_bits, task_id
//  result    out        out_valid / out_stall kind, released_task, flag_word,
//                                             status, last
//  config    in         cfg_we                cfg_wdata (groups_in_use)
//
// A clear, a wait, an unknown group, an unused code or a set on a group with
// no stored waiters is captured at accept, together with its group entry, and
// ends in one sequencer step, S_LOAD. A set on a group with N > 0 stored
// waiters then walks them through S_WRD and S_WEV and ends in S_FIN, since
// each waiter is read from the waiter memory and then tested against the
// flags by the one shared compare unit. A stalled result holds the sequencer
// at its next result. Reset clears the group valid bits, so flags and fill
// counts read as zero at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module event_flag_group_engine #(
	parameter int GROUPS    = efg_pkg::GROUPS_DEF,
	parameter int WAITERS   = efg_pkg::WAITERS_DEF,
	parameter int FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port.
	input  logic                         cfg_we,
	input  logic [efg_pkg::GIU_W-1:0]    cfg_wdata,
	// Request channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [efg_pkg::MODE_W-1:0]   mode,
	input  logic [efg_pkg::GROUP_W-1:0]  group,
	input  logic [efg_pkg::MASK_W-1:0]   mask,
	input  logic                         all_bits,
	input  logic [efg_pkg::TASK_W-1:0]   task_id,
	// Result channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         kind,
	output logic [efg_pkg::TASK_W-1:0]   released_task,
	output logic [efg_pkg::FLAG_W-1:0]   flag_word,
	output logic [efg_pkg::STATUS_W-1:0] status,
	output logic                         last
);

	import efg_pkg::*;

	localparam int DEPTH = GROUPS * WAITERS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CW    = $clog2(WAITERS + 1);
	localparam int FB    = FLAG_BITS;

	typedef struct packed {
		logic [CW-1:0] cnt;
		logic [FB-1:0] flags;
	} grp_ent_t;

	typedef struct packed {
		logic              all;
		logic [TASK_W-1:0] tsk;
		logic [FB-1:0]     msk;
	} waiter_t;

	localparam int WDW = $bits(waiter_t);

	// Test a waiter condition against a flag word.
	function automatic logic wait_met(input logic [FB-1:0] f, input logic [FB-1:0] m,
			input logic a);
		logic hit;
		hit = a ? ((f & m) == m) : ((f & m) != '0);
		return hit;
	endfunction

	state_t              state_q, state_d;
	logic [GIU_W-1:0]    giu_q;
	logic [MODE_W-1:0]   mode_q;
	logic [GROUP_W-1:0]  grp_q;
	logic [FB-1:0]       mask_q;
	logic                all_q;
	logic [TASK_W-1:0]   task_q;
	logic                found_q;
	logic [FB-1:0]       flags_q, flags_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       wcnt_q, wcnt_d;

	logic                out_valid_q;
	logic                kind_q;
	logic [TASK_W-1:0]   task_out_q;
	logic [FLAG_W-1:0]   flag_out_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;

	grp_ent_t            grp_mem [GROUPS];
	logic [GROUPS-1:0]   grp_vld_q;
	grp_ent_t            grp_rd_q;
	logic                grp_hit_q;

	logic                in_acc;
	logic                out_free;
	logic [GW-1:0]       gidx_in;
	logic [GW-1:0]       gidx;
	logic                found_in;
	logic [FB-1:0]       cur_flags;
	logic [CW-1:0]       cur_cnt;

	logic [FB-1:0]       cmp_f;
	logic [FB-1:0]       cmp_m;
	logic                cmp_a;
	logic                cmp_hit;

	logic                emit;
	logic                o_kind;
	logic [TASK_W-1:0]   o_task;
	logic [FB-1:0]       o_flags;
	status_t             o_status;
	logic                o_last;

	logic                gw_en;
	logic [CW-1:0]       gw_cnt;
	logic [FB-1:0]       gw_flags;
	logic                ww_en;
	logic [AW-1:0]       ww_addr;
	waiter_t             ww_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	waiter_t             wr_data;
	logic [WDW-1:0]      wr_raw;

	// Request handshake: one request at a time through the sequencer.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Group lookup for the incoming request.
	assign gidx_in  = GW'(group);
	assign gidx     = GW'(grp_q);
	assign found_in = ({1'b0, group} < giu_q) && (7'(group) < 7'(GROUPS));

	// A group never written reads as zero flags and no waiters.
	assign cur_flags = grp_hit_q ? grp_rd_q.flags : '0;
	assign cur_cnt   = grp_hit_q ? grp_rd_q.cnt : '0;

	assign wr_data = waiter_t'(wr_raw);

	// Shared compare unit: the waiter walk feeds it the stored waiter, the
	// group step feeds it the captured wait request.
	assign cmp_f   = (state_q == S_WEV) ? flags_q : cur_flags;
	assign cmp_m   = (state_q == S_WEV) ? wr_data.msk : mask_q;
	assign cmp_a   = (state_q == S_WEV) ? wr_data.all : all_q;
	assign cmp_hit = wait_met(cmp_f, cmp_m, cmp_a);

	// Sequencer.
	always_comb begin
		state_d  = state_q;
		flags_d  = flags_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		wcnt_d   = wcnt_q;
		emit     = 1'b0;
		o_kind   = KIND_RESULT;
		o_task   = '0;
		o_flags  = flags_q;
		o_status = ST_DONE;
		o_last   = 1'b1;
		gw_en    = 1'b0;
		gw_cnt   = cnt_q;
		gw_flags = flags_q;
		ww_en    = 1'b0;
		ww_addr  = AW'(int'(gidx) * WAITERS + int'(wcnt_q));
		ww_data  = wr_data;
		wr_en    = 1'b0;
		wr_addr  = AW'(int'(gidx) * WAITERS + int'(idx_q));
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (out_free) begin
					state_d = S_IDLE;
					if (!found_q) begin
						emit     = 1'b1;
						o_flags  = '0;
						o_status = ST_NOGRP;
					end else begin
						case (mode_t'(mode_q))
							MODE_SET: begin
								flags_d = cur_flags | mask_q;
								cnt_d   = cur_cnt;
								idx_d   = '0;
								wcnt_d  = '0;
								if (cur_cnt == '0) begin
									emit     = 1'b1;
									o_flags  = cur_flags | mask_q;
									gw_en    = 1'b1;
									gw_cnt   = '0;
									gw_flags = cur_flags | mask_q;
								end else begin
									state_d = S_WRD;
								end
							end
							MODE_CLR: begin
								emit     = 1'b1;
								o_flags  = cur_flags & ~mask_q;
								gw_en    = 1'b1;
								gw_cnt   = cur_cnt;
								gw_flags = cur_flags & ~mask_q;
							end
							MODE_WAIT: begin
								emit = 1'b1;
								if (cmp_hit) begin
									o_task   = task_q;
									o_flags  = cur_flags & ~mask_q;
									gw_en    = 1'b1;
									gw_cnt   = cur_cnt;
									gw_flags = cur_flags & ~mask_q;
								end else if (cur_cnt < CW'(WAITERS)) begin
									o_flags     = cur_flags;
									o_status    = ST_BLOCKED;
									ww_en       = 1'b1;
									ww_addr     = AW'(int'(gidx) * WAITERS + int'(cur_cnt));
									ww_data.all = all_q;
									ww_data.tsk = task_q;
									ww_data.msk = mask_q;
									gw_en       = 1'b1;
									gw_cnt      = cur_cnt + CW'(1);
									gw_flags    = cur_flags;
								end else begin
									o_flags  = cur_flags;
									o_status = ST_FULL;
								end
							end
							default: begin
								emit    = 1'b1;
								o_flags = cur_flags;
							end
						endcase
					end
				end
			end
			S_WRD: begin
				wr_en   = 1'b1;
				state_d = S_WEV;
			end
			S_WEV: begin
				if (out_free) begin
					idx_d   = idx_q + CW'(1);
					state_d = ((idx_q + CW'(1)) == cnt_q) ? S_FIN : S_WRD;
					if (cmp_hit) begin
						flags_d = flags_q & ~wr_data.msk;
						emit    = 1'b1;
						o_kind  = KIND_RELEASE;
						o_task  = wr_data.tsk;
						o_flags = flags_q & ~wr_data.msk;
						o_last  = 1'b0;
					end else begin
						// Survivors move down to keep the table packed.
						ww_en  = 1'b1;
						wcnt_d = wcnt_q + CW'(1);
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit     = 1'b1;
					gw_en    = 1'b1;
					gw_cnt   = wcnt_q;
					gw_flags = flags_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			giu_q       <= GIU_RESET;
			out_valid_q <= 1'b0;
			grp_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				giu_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (gw_en) begin
				grp_vld_q[gidx] <= 1'b1;
			end
		end
	end

	// Request capture and working registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q    <= mode;
			grp_q     <= group;
			mask_q    <= FB'(mask);
			all_q     <= all_bits;
			task_q    <= task_id;
			found_q   <= found_in;
			grp_rd_q  <= grp_mem[gidx_in];
			grp_hit_q <= grp_vld_q[gidx_in];
		end
		flags_q <= flags_d;
		cnt_q   <= cnt_d;
		idx_q   <= idx_d;
		wcnt_q  <= wcnt_d;
	end

	// Group entry memory write.
	always_ff @(posedge clk) begin
		if (gw_en) begin
			grp_mem[gidx] <= {gw_cnt, gw_flags};
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q     <= o_kind;
			task_out_q <= o_task;
			flag_out_q <= FLAG_W'(o_flags);
			status_q   <= o_status;
			last_q     <= o_last;
		end
	end

	// Waiter table storage.
	efg_waiter_ram #(
		.DEPTH (DEPTH),
		.DW    (WDW)
	) u_waiter_ram (
		.clk   (clk),
		.we    (ww_en),
		.waddr (ww_addr),
		.wdata (ww_data),
		.re    (wr_en),
		.raddr (wr_addr),
		.rdata (wr_raw)
	);

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign released_task = task_out_q;
	assign flag_word     = flag_out_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule
